@@ rtl/bds_pkg.sv @@
`timescale 1ns / 1ps

package bds_pkg;

    localparam int PIX_W  = 32;
    localparam int LANE_W = 12;
    localparam int SUM_W  = 4 * LANE_W;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int WIDTH_RESET  = 2048;
    localparam int HEIGHT_RESET = 4;
    localparam int MIN_DIM      = 4;

    localparam int CFG_AW       = 3;
    localparam int CFG_DW       = 32;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;

    // register select is paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // one tile-column step handed from the scanner to the accumulator
    typedef struct packed {
        logic [SUM_W-1:0] tp;
        logic             first_row;
        logic             last_row;
        logic             row_end;
        logic             frame_end;
    } t_item;

    function automatic int clamp_dim(input int v, input int top);
        int r;
        r = v;
        if (v < MIN_DIM) begin
            r = MIN_DIM;
        end else if (v > top) begin
            r = top;
        end
        return r;
    endfunction

    // four 8-bit channels into four 12-bit lanes
    function automatic logic [SUM_W-1:0] spread(input logic [PIX_W-1:0] px);
        return {4'b0, px[31:24], 4'b0, px[23:16], 4'b0, px[15:8], 4'b0, px[7:0]};
    endfunction

    // each lane divided by 16, packed back into 32 bits
    function automatic logic [PIX_W-1:0] average(input logic [SUM_W-1:0] s);
        return {s[47:40], s[35:28], s[23:16], s[11:4]};
    endfunction

endpackage

@@ rtl/box_downscale_4x4_argb.sv @@
`timescale 1ns / 1ps
// Throughput: one pixel per clock unless m_axis stalls; no gaps between frames.
// A tile average reaches m_axis through stage one, loaded with the column-sum read as
// its last pixel is taken, and then the output register.
// Column-sum store: one RAM port pair, read per tile column, not written on last rows.
// Reset: position counters and handshake state clear; region resets to 2048 x 4.
// Column sums are not cleared; each entry in use is written on a band's first row.

module box_downscale_4x4_argb #(
    parameter int MAX_WIDTH  = bds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bds_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bds_pkg::CFG_AW-1:0] paddr,
    input  logic [bds_pkg::CFG_DW-1:0] pwdata,
    output logic [bds_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    // source stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // [31:0] source_pixel
    // result stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,  // [31:0] averaged_pixel
    output logic                       m_axis_tlast,  // row_end
    output logic                       m_axis_tuser   // [0] frame_end
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = ((MAX_WIDTH / 4) > 1) ? $clog2(MAX_WIDTH / 4) : 1;

    logic [WW-1:0]  width;
    logic [HW-1:0]  height;
    logic           restart;
    logic           item_valid;
    bds_pkg::t_item item;
    logic [AW-1:0]  item_addr;
    logic           tile_ready;

    bds_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .WW        (WW),
        .HW        (HW)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_width  (width),
        .o_height (height),
        .o_restart(restart)
    );

    bds_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .WW        (WW),
        .HW        (HW),
        .AW        (AW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (width),
        .i_height    (height),
        .i_restart   (restart),
        .i_valid     (s_axis_tvalid),
        .i_ready     (tile_ready),
        .i_pixel     (s_axis_tdata),
        .o_item_valid(item_valid),
        .o_item      (item),
        .o_addr      (item_addr)
    );

    bds_tile #(
        .MAX_WIDTH(MAX_WIDTH),
        .AW       (AW)
    ) u_tile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(item_valid),
        .i_item      (item),
        .i_addr      (item_addr),
        .o_ready     (tile_ready),
        .o_valid     (m_axis_tvalid),
        .o_data      (m_axis_tdata),
        .o_row_end   (m_axis_tlast),
        .o_frame_end (m_axis_tuser),
        .i_out_ready (m_axis_tready)
    );

    assign s_axis_tready = tile_ready;

endmodule

@@ rtl/bds_ram.sv @@
`timescale 1ns / 1ps

module bds_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bds_cfg.sv @@
`timescale 1ns / 1ps

module bds_cfg #(
    parameter int MAX_WIDTH  = bds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bds_pkg::DEF_MAX_HEIGHT,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bds_pkg::CFG_AW-1:0] paddr,
    input  logic [bds_pkg::CFG_DW-1:0] pwdata,
    output logic [bds_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output logic [WW-1:0]              o_width,
    output logic [HW-1:0]              o_height,
    output logic                       o_restart
);

    localparam int WIDTH_C_RESET  = bds_pkg::clamp_dim(bds_pkg::WIDTH_RESET, MAX_WIDTH);
    localparam int HEIGHT_C_RESET = bds_pkg::clamp_dim(bds_pkg::HEIGHT_RESET, MAX_HEIGHT);

    logic [bds_pkg::WIDTH_REG_W-1:0]  r_width_raw;
    logic [bds_pkg::HEIGHT_REG_W-1:0] r_height_raw;
    logic [WW-1:0]                    r_width_c;
    logic [HW-1:0]                    r_height_c;
    logic                             wr;

    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_raw  <= bds_pkg::WIDTH_REG_W'(bds_pkg::WIDTH_RESET);
            r_height_raw <= bds_pkg::HEIGHT_REG_W'(bds_pkg::HEIGHT_RESET);
            r_width_c    <= WW'(WIDTH_C_RESET);
            r_height_c   <= HW'(HEIGHT_C_RESET);
        end else if (wr) begin
            unique case (paddr[2])
                bds_pkg::REG_WIDTH: begin
                    r_width_raw <= pwdata[bds_pkg::WIDTH_REG_W-1:0];
                    r_width_c   <= WW'(bds_pkg::clamp_dim(
                        int'(pwdata[bds_pkg::WIDTH_REG_W-1:0]), MAX_WIDTH));
                end
                bds_pkg::REG_HEIGHT: begin
                    r_height_raw <= pwdata[bds_pkg::HEIGHT_REG_W-1:0];
                    r_height_c   <= HW'(bds_pkg::clamp_dim(
                        int'(pwdata[bds_pkg::HEIGHT_REG_W-1:0]), MAX_HEIGHT));
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            bds_pkg::REG_WIDTH:  prdata = bds_pkg::CFG_DW'(r_width_raw);
            bds_pkg::REG_HEIGHT: prdata = bds_pkg::CFG_DW'(r_height_raw);
            default:             prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign o_width   = r_width_c;
    assign o_height  = r_height_c;
    assign o_restart = wr;

endmodule

@@ rtl/bds_scan.sv @@
`timescale 1ns / 1ps

module bds_scan #(
    parameter int MAX_WIDTH  = bds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bds_pkg::DEF_MAX_HEIGHT,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1),
    parameter int AW         = ((MAX_WIDTH / 4) > 1) ? $clog2(MAX_WIDTH / 4) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [WW-1:0]             i_width,
    input  logic [HW-1:0]             i_height,
    input  logic                      i_restart,
    input  logic                      i_valid,
    input  logic                      i_ready,
    input  logic [bds_pkg::PIX_W-1:0] i_pixel,
    output logic                      o_item_valid,
    output bds_pkg::t_item            o_item,
    output logic [AW-1:0]             o_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]             r_col;
    logic [RW-1:0]             r_row;
    logic [bds_pkg::SUM_W-1:0] r_tp;
    logic [bds_pkg::SUM_W-1:0] n_tp;

    logic          accept;
    logic [WW-1:0] col_x;
    logic [HW-1:0] row_x;
    logic [WW-1:0] used_w;
    logic [HW-1:0] used_h;
    logic          in_region;
    logic          col_wrap;
    logic          row_wrap;
    logic          tile_col_end;
    logic [CW-1:0] col_tile;

    assign accept       = i_valid && i_ready;
    assign col_x        = WW'(r_col);
    assign row_x        = HW'(r_row);
    assign used_w       = {i_width[WW-1:2], 2'b00};
    assign used_h       = {i_height[HW-1:2], 2'b00};
    assign in_region    = (col_x < used_w) && (row_x < used_h);
    assign col_wrap     = (col_x == i_width - 1'b1);
    assign row_wrap     = (row_x == i_height - 1'b1);
    assign tile_col_end = (r_col[1:0] == 2'b11);
    assign col_tile     = r_col >> 2;

    assign n_tp = ((r_col[1:0] == 2'b00) ? '0 : r_tp) + bds_pkg::spread(i_pixel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // running sum over the first three pixels of the tile row
    always_ff @(posedge i_clk) begin
        if (accept && in_region && !tile_col_end) begin
            r_tp <= n_tp;
        end
    end

    assign o_item_valid     = accept && in_region && tile_col_end;
    assign o_item.tp        = n_tp;
    assign o_item.first_row = (r_row[1:0] == 2'b00);
    assign o_item.last_row  = (r_row[1:0] == 2'b11);
    assign o_item.row_end   = (col_x == used_w - 1'b1);
    assign o_item.frame_end = (col_x == used_w - 1'b1) && (row_x == used_h - 1'b1);
    assign o_addr           = col_tile[AW-1:0];

endmodule

@@ rtl/bds_tile.sv @@
`timescale 1ns / 1ps

module bds_tile #(
    parameter int MAX_WIDTH = bds_pkg::DEF_MAX_WIDTH,
    parameter int AW        = ((MAX_WIDTH / 4) > 1) ? $clog2(MAX_WIDTH / 4) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_item_valid,
    input  bds_pkg::t_item            i_item,
    input  logic [AW-1:0]             i_addr,
    output logic                      o_ready,
    output logic                      o_valid,
    output logic [bds_pkg::PIX_W-1:0] o_data,
    output logic                      o_row_end,
    output logic                      o_frame_end,
    input  logic                      i_out_ready
);

    localparam int TILE_COLS = MAX_WIDTH / 4;

    logic                      r_s1_valid;
    bds_pkg::t_item            r_s1;
    logic [AW-1:0]             r_s1_addr;
    logic                      r_o_valid;
    logic [bds_pkg::PIX_W-1:0] r_o_data;
    logic                      r_o_row_end;
    logic                      r_o_frame_end;

    logic                      out_free;
    logic                      s1_move;
    logic [bds_pkg::SUM_W-1:0] col_q;
    logic [bds_pkg::SUM_W-1:0] sum;

    assign out_free = !r_o_valid || i_out_ready;
    assign s1_move  = r_s1_valid && (!r_s1.last_row || out_free);
    assign o_ready  = !r_s1_valid || s1_move;

    // read issued as the item is taken; data is ready while it sits in stage 1
    bds_ram #(
        .WIDTH (bds_pkg::SUM_W),
        .DEPTH (TILE_COLS),
        .ADDR_W(AW)
    ) u_col_sums (
        .i_clk  (i_clk),
        .i_we   (s1_move && !r_s1.last_row),
        .i_waddr(r_s1_addr),
        .i_wdata(sum),
        .i_re   (i_item_valid),
        .i_raddr(i_addr),
        .o_rdata(col_q)
    );

    assign sum = r_s1.first_row ? r_s1.tp : col_q + r_s1.tp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item_valid) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item_valid) begin
            r_s1      <= i_item;
            r_s1_addr <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move && r_s1.last_row) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1.last_row) begin
            r_o_data      <= bds_pkg::average(sum);
            r_o_row_end   <= r_s1.row_end;
            r_o_frame_end <= r_s1.frame_end;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_data      = r_o_data;
    assign o_row_end   = r_o_row_end;
    assign o_frame_end = r_o_frame_end;

endmodule
